[rtl/core/oeu_pkg.sv]
// Shared types and constants for the octal escape unescaper.
`timescale 1ns / 1ps
package oeu_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_W           = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] DIGIT0 = 8'h30;
  localparam logic [7:0] DIGIT3 = 8'h33;
  localparam logic [7:0] DIGIT7 = 8'h37;
  localparam logic [7:0] END_MARK = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  // One queued job: up to three data bytes, then an optional end record.
  typedef struct packed {
    logic [1:0]            n_data;
    logic                  has_end;
    logic [2:0][7:0]       bytes;
    logic [LEN_W-1:0]      length;
  } job_t;

endpackage

[rtl/core/oeu_front.sv]
// Front end: escape state machine that turns each accepted byte into at most one job.
`timescale 1ns / 1ps
module oeu_front #(
  parameter int LENGTH_BITS = oeu_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        text_byte,
  output logic              job_push,
  output oeu_pkg::job_t     job
);

  oeu_pkg::phase_t        phase, phase_next;
  logic [1:0]             held1, held1_next;
  logic [2:0]             held2, held2_next;
  logic [LENGTH_BITS-1:0] count, count_next;

  logic                   plain;
  logic [1:0]             nd;
  logic [2:0][7:0]        bytes;
  logic                   has_end;
  logic                   is_oct;
  logic                   is_low;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS-1:0] count_sat;
  logic [LENGTH_BITS+oeu_pkg::LEN_W-1:0] count_ext;

  assign is_oct = (text_byte >= oeu_pkg::DIGIT0) && (text_byte <= oeu_pkg::DIGIT7);
  assign is_low = (text_byte >= oeu_pkg::DIGIT0) && (text_byte <= oeu_pkg::DIGIT3);

  always_comb begin
    phase_next = phase;
    held1_next = held1;
    held2_next = held2;
    plain      = 1'b0;
    nd         = 2'd0;
    bytes      = '0;
    has_end    = 1'b0;
    unique case (phase)
      oeu_pkg::PH_IDLE: begin
        plain = 1'b1;
      end
      oeu_pkg::PH_ESC: begin
        if (text_byte == oeu_pkg::BSLASH) begin
          bytes[0]   = oeu_pkg::BSLASH;
          nd         = 2'd1;
          phase_next = oeu_pkg::PH_IDLE;
        end else if (is_low) begin
          held1_next = text_byte[1:0];
          phase_next = oeu_pkg::PH_DIG1;
        end else begin
          phase_next = oeu_pkg::PH_IDLE;
          plain      = 1'b1;
        end
      end
      oeu_pkg::PH_DIG1: begin
        if (is_oct) begin
          held2_next = text_byte[2:0];
          phase_next = oeu_pkg::PH_DIG2;
        end else begin
          bytes[0]   = {6'b001100, held1};
          nd         = 2'd1;
          phase_next = oeu_pkg::PH_IDLE;
          plain      = 1'b1;
        end
      end
      oeu_pkg::PH_DIG2: begin
        if (is_oct) begin
          bytes[0] = {held1, held2, text_byte[2:0]};
          nd       = 2'd1;
        end else begin
          bytes[0] = {6'b001100, held1};
          bytes[1] = {5'b00110, held2};
          nd       = 2'd2;
          plain    = 1'b1;
        end
        phase_next = oeu_pkg::PH_IDLE;
      end
      default: begin
        phase_next = oeu_pkg::PH_IDLE;
      end
    endcase

    if (plain) begin
      if (text_byte == oeu_pkg::END_MARK) begin
        has_end    = 1'b1;
        phase_next = oeu_pkg::PH_IDLE;
        held1_next = '0;
        held2_next = '0;
      end else if (text_byte == oeu_pkg::BSLASH) begin
        phase_next = oeu_pkg::PH_ESC;
      end else begin
        bytes[nd] = text_byte;
        nd        = nd + 2'd1;
      end
    end
  end

  // Saturating count: adding at most three to a value at or below the
  // maximum overflows exactly when the carry is set.
  assign sum       = {1'b0, count} + {{(LENGTH_BITS-1){1'b0}}, nd};
  assign count_sat = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
  assign count_ext = {{oeu_pkg::LEN_W{1'b0}}, count_sat};
  assign count_next = has_end ? '0 : count_sat;

  assign job_push     = take && ((nd != 2'd0) || has_end);
  assign job.n_data   = nd;
  assign job.has_end  = has_end;
  assign job.bytes    = bytes;
  assign job.length   = count_ext[oeu_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= oeu_pkg::PH_IDLE;
      held1 <= '0;
      held2 <= '0;
      count <= '0;
    end else if (take) begin
      phase <= phase_next;
      held1 <= held1_next;
      held2 <= held2_next;
      count <= count_next;
    end
  end

endmodule

[rtl/core/oeu_queue.sv]
// Short job queue between front end and back end.
`timescale 1ns / 1ps
module oeu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  oeu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output oeu_pkg::job_t head
);

  localparam int D  = oeu_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  oeu_pkg::job_t entries [D];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    if (p == PW'(D - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full  = (count == CW'(D));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/core/oeu_back.sv]
// Back end: expands each job into results, one per cycle unless stalled, into the output register.
`timescale 1ns / 1ps
module oeu_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     job_valid,
  input  oeu_pkg::job_t            job,
  output logic                     job_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic [7:0]               data_byte,
  output logic                     is_data,
  output logic                     run_last,
  output logic [oeu_pkg::LEN_W-1:0] decoded_length
);

  logic [1:0] sel;
  logic       out_valid;
  logic       load;
  logic       cur_data;
  logic       cur_last;
  logic [2:0] total;
  logic [7:0] cur_byte;

  assign total    = {1'b0, job.n_data} + {2'b00, job.has_end};
  assign cur_data = (sel < job.n_data);
  assign cur_last = (({1'b0, sel} + 3'd1) == total);

  always_comb begin
    case (sel)
      2'd0:    cur_byte = job.bytes[0];
      2'd1:    cur_byte = job.bytes[1];
      2'd2:    cur_byte = job.bytes[2];
      default: cur_byte = '0;
    endcase
  end

  assign load    = job_valid && (!out_valid || pop);
  assign job_pop = load && cur_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= cur_last ? 2'd0 : sel + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte      <= cur_data ? cur_byte : 8'h00;
      is_data        <= cur_data;
      run_last       <= cur_last;
      decoded_length <= cur_data ? '0 : job.length;
    end
  end

endmodule

[rtl/core/octal_escape_unescaper.sv]
// Top level of the backslash octal escape unescaper.
// The results of a byte reach the output ports through the job queue write and then
// the output register load.
// Throughput: one byte per cycle while the queue is not full; a byte yields at most
// three results, which leave the single output register one at a time.
// Reset (rst, synchronous): escape phase, held digits, length count, the job
// queue and the output valid flag clear; full and empty settle to low and high.
`timescale 1ns / 1ps
module octal_escape_unescaper #(
  parameter int LENGTH_BITS = oeu_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                text_byte,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                data_byte,
  output logic                      is_data,
  output logic                      run_last,
  output logic [oeu_pkg::LEN_W-1:0] decoded_length
);

  // Input transfer: the front end advances its escape state on every accepted byte.
  logic          take;
  logic          job_push;
  oeu_pkg::job_t job_in;

  // Queue head toward the back end.
  logic          job_valid;
  logic          job_pop;
  oeu_pkg::job_t job_head;

  assign take = push && !full;

  // Classify each byte and pack its results into one job.
  oeu_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Hold jobs so a stalled consumer does not stop the front at once.
  // Bytes that yield nothing (an opening backslash, a held digit) push no job.
  oeu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .full     (full),
    .pop      (job_pop),
    .valid    (job_valid),
    .head     (job_head)
  );

  // Drain each job one result per cycle while pop allows; the last one carries run_last.
  oeu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job_head),
    .job_pop        (job_pop),
    .pop            (pop),
    .empty          (empty),
    .data_byte      (data_byte),
    .is_data        (is_data),
    .run_last       (run_last),
    .decoded_length (decoded_length)
  );

endmodule

[rtl/core/oeu_checker.sv]
// Port-level checks for the octal escape unescaper, bound to the top level.
`timescale 1ns / 1ps
module oeu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [7:0]                data_byte,
  input logic                      is_data,
  input logic                      run_last,
  input logic [oeu_pkg::LEN_W-1:0] decoded_length
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queue not cleared after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(is_data) &&
                          $stable(run_last) && $stable(decoded_length)))
    else $error("stalled result changed");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_data) |-> (run_last && data_byte == 8'h00))
    else $error("end record not last of its byte");

  a_data_no_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_data) |-> (decoded_length == '0))
    else $error("data result carries a length");

endmodule

bind octal_escape_unescaper oeu_checker u_oeu_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .data_byte      (data_byte),
  .is_data        (is_data),
  .run_last       (run_last),
  .decoded_length (decoded_length)
);

[tb/tb_top.sv]
// Self-checking testbench for the octal escape unescaper: directed table, random texts.
`timescale 1ns / 1ps
module tb_top;

  // One result transfer as seen on the output ports.
  typedef struct packed {
    logic [7:0]                data_byte;
    logic                      is_data;
    logic                      run_last;
    logic [oeu_pkg::LEN_W-1:0] decoded_length;
  } result_t;

  // One row of the directed table. When typed is set, want is the single result
  // this byte must cause; otherwise the decoder model supplies the results.
  typedef struct packed {
    logic [7:0] text;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam int N_DIRECTED = 26;
  localparam longint unsigned LEN_CAP = (64'd1 << oeu_pkg::LENGTH_BITS_DEF) - 64'd1;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic [7:0]                text_byte = '0;
  logic                      pop = 1'b0;
  logic                      full;
  logic                      empty;
  logic [7:0]                data_byte;
  logic                      is_data;
  logic                      run_last;
  logic [oeu_pkg::LEN_W-1:0] decoded_length;

  // Decoder model state: escape phase, held digits, bytes decoded in this text.
  oeu_pkg::phase_t  esc_phase = oeu_pkg::PH_IDLE;
  logic [1:0]       first_digit = '0;
  logic [2:0]       second_digit = '0;
  longint unsigned  text_len = 0;

  result_t          step_results[$];    // results of the byte being decoded
  result_t          awaited_records[$]; // results still owed by the block, oldest first
  stim_row_t        directed_rows[N_DIRECTED];
  int unsigned      bytes_fed = 0;
  int unsigned      mismatches = 0;
  int unsigned      stall_left = 0;
  bit               feed_gaps_on = 1'b1;
  bit               drain_stalls_on = 1'b1;

  octal_escape_unescaper DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .empty          (empty),
    .pop            (pop),
    .data_byte      (data_byte),
    .is_data        (is_data),
    .run_last       (run_last),
    .decoded_length (decoded_length)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------
  function automatic logic is_octal(logic [7:0] c);
    return (c >= oeu_pkg::DIGIT0) && (c <= oeu_pkg::DIGIT7);
  endfunction

  // Append a decoded data byte and bump the saturating length count.
  function automatic void emit_data(logic [7:0] b);
    step_results.push_back('{data_byte: b, is_data: 1'b1, run_last: 1'b0,
                             decoded_length: '0});
    if (text_len < LEN_CAP) text_len++;
  endfunction

  // Decode one text byte into step_results and advance the model state.
  function automatic void decode_text_byte(logic [7:0] c);
    logic    plain;
    result_t last;
    plain = 1'b0;
    step_results.delete();
    case (esc_phase)
      oeu_pkg::PH_IDLE: begin
        plain = 1'b1;
      end
      oeu_pkg::PH_ESC: begin
        if (c == oeu_pkg::BSLASH) begin
          emit_data(oeu_pkg::BSLASH);
          esc_phase = oeu_pkg::PH_IDLE;
        end else if (c >= oeu_pkg::DIGIT0 && c <= oeu_pkg::DIGIT3) begin
          first_digit = c[1:0];
          esc_phase = oeu_pkg::PH_DIG1;
        end else begin
          // Broken escape: drop the backslash, re-read c as ordinary text.
          esc_phase = oeu_pkg::PH_IDLE;
          plain = 1'b1;
        end
      end
      oeu_pkg::PH_DIG1: begin
        if (is_octal(c)) begin
          second_digit = c[2:0];
          esc_phase = oeu_pkg::PH_DIG2;
        end else begin
          emit_data(oeu_pkg::DIGIT0 + first_digit);
          esc_phase = oeu_pkg::PH_IDLE;
          plain = 1'b1;
        end
      end
      default: begin
        if (is_octal(c)) begin
          emit_data({first_digit, second_digit, c[2:0]});
        end else begin
          emit_data(oeu_pkg::DIGIT0 + first_digit);
          emit_data(oeu_pkg::DIGIT0 + second_digit);
          plain = 1'b1;
        end
        esc_phase = oeu_pkg::PH_IDLE;
      end
    endcase
    if (plain) begin
      if (c == oeu_pkg::END_MARK) begin
        // End record carries the count masked to the port width, then a new text starts.
        step_results.push_back('{data_byte: '0, is_data: 1'b0, run_last: 1'b0,
                                 decoded_length: text_len[oeu_pkg::LEN_W-1:0]});
        esc_phase = oeu_pkg::PH_IDLE;
        first_digit = '0;
        second_digit = '0;
        text_len = 0;
      end else if (c == oeu_pkg::BSLASH) begin
        esc_phase = oeu_pkg::PH_ESC;
      end else begin
        emit_data(c);
      end
    end
    if (step_results.size() != 0) begin
      last = step_results.pop_back();
      last.run_last = 1'b1;
      step_results.push_back(last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t via_model(logic [7:0] b);
    return '{text: b, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t typed_data(logic [7:0] b, logic [7:0] want_byte);
    return '{text: b, typed: 1'b1,
             want: '{data_byte: want_byte, is_data: 1'b1, run_last: 1'b1,
                     decoded_length: '0}};
  endfunction

  function automatic stim_row_t typed_end(logic [oeu_pkg::LEN_W-1:0] len);
    return '{text: oeu_pkg::END_MARK, typed: 1'b1,
             want: '{data_byte: '0, is_data: 1'b0, run_last: 1'b1, decoded_length: len}};
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Present one byte, hold it until the transfer, then record what it owes.
  // A random gap may come first while gaps are enabled.
  task automatic feed_text_byte(logic [7:0] b, logic typed, result_t want);
    if (feed_gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    push <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_fed++;
    decode_text_byte(b);
    if (typed) begin
      awaited_records.push_back(want);
    end else begin
      foreach (step_results[i]) awaited_records.push_back(step_results[i]);
    end
  endtask

  task automatic feed(logic [7:0] b);
    feed_text_byte(b, 1'b0, '0);
  endtask

  // Any byte but end mark and backslash.
  function automatic logic [7:0] random_char();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == oeu_pkg::BSLASH) b = 8'($urandom_range(1, int'(oeu_pkg::BSLASH) - 1));
    return b;
  endfunction

  // Backslash followed by up to two valid leading digits.
  task automatic feed_escape_head(int unsigned n_digits);
    feed(oeu_pkg::BSLASH);
    if (n_digits >= 1) feed(8'(oeu_pkg::DIGIT0 + $urandom_range(0, 3)));
    if (n_digits >= 2) feed(8'(oeu_pkg::DIGIT0 + $urandom_range(0, 7)));
  endtask

  // One text: mostly plain bytes and well-formed escapes, some broken escapes
  // with a random follower, sometimes a dangling escape right before the end mark.
  task automatic feed_random_text();
    int unsigned n_tokens;
    n_tokens = $urandom_range(0, 12);
    repeat (n_tokens) begin
      case ($urandom_range(0, 9)) inside
        [0:4]: begin
          feed(random_char());
        end
        5: begin
          feed(oeu_pkg::BSLASH);
          feed(oeu_pkg::BSLASH);
        end
        [6:7]: begin
          feed_escape_head(2);
          feed(8'(oeu_pkg::DIGIT0 + $urandom_range(0, 7)));
        end
        default: begin
          feed_escape_head($urandom_range(0, 2));
          feed(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) feed_escape_head($urandom_range(0, 2));
    feed(oeu_pkg::END_MARK);
  endtask

  // Stop sending and hold until every owed result has transferred.
  task automatic wait_drained();
    push <= 1'b0;
    while (awaited_records.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: pop high except during random stall bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (drain_stalls_on && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: compare every transfer against the oldest owed result.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [oeu_pkg::LEN_W-1:0] want,
                                      logic [oeu_pkg::LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_records.size() == 0) begin
        $error("result with none owed: data_byte %0h is_data %0b run_last %0b length %0h",
               data_byte, is_data, run_last, decoded_length);
        mismatches++;
      end else begin
        want = awaited_records.pop_front();
        check_field("data_byte", oeu_pkg::LEN_W'(want.data_byte),
                    oeu_pkg::LEN_W'(data_byte));
        check_field("is_data", oeu_pkg::LEN_W'(want.is_data), oeu_pkg::LEN_W'(is_data));
        check_field("run_last", oeu_pkg::LEN_W'(want.run_last),
                    oeu_pkg::LEN_W'(run_last));
        check_field("decoded_length", want.decoded_length, decoded_length);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned first_random;
    directed_rows = '{
      typed_data(8'h41, 8'h41),     // plain letter
      typed_data(8'hFF, 8'hFF),     // top byte value passes through
      typed_end(16'd2),             // end of a two byte text
      typed_end(16'd0),             // empty text
      via_model(oeu_pkg::BSLASH),
      typed_data(oeu_pkg::BSLASH, oeu_pkg::BSLASH), // double backslash gives one
      via_model(oeu_pkg::BSLASH),
      via_model(oeu_pkg::DIGIT3),
      via_model(oeu_pkg::DIGIT7),
      typed_data(oeu_pkg::DIGIT7, 8'hFF),  // largest octal escape
      via_model(oeu_pkg::BSLASH),
      typed_data(8'h78, 8'h78),     // broken escape: backslash dropped, letter kept
      via_model(oeu_pkg::BSLASH),
      via_model(8'h31),
      via_model(oeu_pkg::DIGIT7),
      via_model(oeu_pkg::BSLASH),   // two digits held, new backslash opens an escape
      via_model(8'h34),             // digit above 3 after a backslash is plain text
      via_model(oeu_pkg::BSLASH),
      via_model(oeu_pkg::DIGIT0),
      via_model(8'h35),
      via_model(oeu_pkg::END_MARK), // two held digits, then the end record
      via_model(oeu_pkg::BSLASH),
      via_model(8'h32),
      via_model(oeu_pkg::END_MARK), // one held digit, then the end record
      via_model(oeu_pkg::BSLASH),
      typed_end(16'd0)              // lone backslash at end is discarded
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      feed_text_byte(directed_rows[i].text, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_drained();

    // Random texts; the tail runs with no gaps and no stalls.
    feed_gaps_on = 1'b1;
    drain_stalls_on = 1'b1;
    first_random = bytes_fed;
    while (bytes_fed - first_random < 240) begin
      if (bytes_fed - first_random >= 200) begin
        feed_gaps_on = 1'b0;
        drain_stalls_on = 1'b0;
      end
      feed_random_text();
    end
    wait_drained();

    // Allow a stray late result to show up before the verdict.
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on run length.
  initial begin : watchdog
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
